// File: src/drum_step_sequencer_defines.svh
// ============================================================================
// Drum step sequencer assertion macros
// Shared concurrent assertion templates for the sequencer RTL.
// ============================================================================
`ifndef DRUM_STEP_SEQUENCER_DEFINES_SVH
`define DRUM_STEP_SEQUENCER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define DSS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dss_pkg.sv
// ============================================================================
// Drum step sequencer package
// Sizes, constants, request payload types and helper functions.
// ============================================================================
package dss_pkg;

    // Pattern store geometry.
    localparam int NUM_STEPS = 16;
    localparam int NUM_ROWS  = 5;
    localparam int STEP_W    = (NUM_STEPS > 2) ? $clog2(NUM_STEPS) : 1;
    localparam int ROW_W     = $clog2(NUM_ROWS);
    localparam int DRUM_CNT  = 4;

    // Field widths of the channels.
    localparam int BEAT_W     = 16;
    localparam int TICK_W     = 16;
    localparam int TEMPO_W    = 8;
    localparam int MIDI_W     = 8;
    localparam int POS_W      = 4;
    localparam int ROW_OUT_W  = 3;
    localparam int DISP_OUT_W = 11;

    // Display word: step*100 + cursor, wide enough for the largest step count.
    localparam int DISP_NEED = $clog2((NUM_STEPS - 1) * 100 + NUM_STEPS);
    localparam int DISP_W    = (DISP_NEED > DISP_OUT_W) ? DISP_NEED : DISP_OUT_W;

    // Serial divider sizing.
    localparam int DIV_STEPS = BEAT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Constants.
    localparam logic [BEAT_W-1:0]  BEAT_RESET  = 16'd15000;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 8'd120;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 8'd10;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 8'd250;
    localparam logic [MIDI_W-1:0]  NOTE_ON     = 8'h90;
    localparam logic [MIDI_W-1:0]  NOTE_BASE   = 8'h24;
    localparam int                 DISP_SCALE  = 100;

    // Encoder movement codes.
    typedef enum logic [1:0] {
        ENC_NONE = 2'd0,
        ENC_UP   = 2'd1,
        ENC_DOWN = 2'd2
    } enc_dir_t;

    // One poll of the front panel.
    typedef struct packed {
        logic              tick;
        logic              fwd_switch_n;
        logic              back_switch_n;
        logic              edit_button;
        logic              left_enc_a;
        logic              left_enc_b;
        logic              right_enc_a;
        logic              right_enc_b;
        logic              midi_valid;
        logic [MIDI_W-1:0] midi_byte;
    } dss_in_t;

    // One status result.
    typedef struct packed {
        logic [DRUM_CNT-1:0]   drum_triggers;
        logic [POS_W-1:0]      play_position;
        logic [POS_W-1:0]      cursor_position;
        logic [ROW_OUT_W-1:0]  edit_row;
        logic [TEMPO_W-1:0]    tempo_now;
        logic [DISP_OUT_W-1:0] display_value;
    } dss_out_t;

    // Reset contents of one pattern row.
    function automatic logic [NUM_STEPS-1:0] row_reset(input int row);
        logic [NUM_STEPS-1:0] bits;
        bits = '0;
        for (int c = 0; c < NUM_STEPS; c++)
        begin
            if (row == 0 || (row == 4 && (c % 4) == 0))
            begin
                bits[c] = 1'b1;
            end
        end
        return bits;
    endfunction

    // Quadrature decode: Gray sequence 0-1-3-2-0 counts up.
    function automatic enc_dir_t enc_decode(input logic [1:0] last, input logic [1:0] now);
        enc_dir_t dir;
        unique case ({last, now})
            4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: dir = ENC_UP;
            4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: dir = ENC_DOWN;
            default:                                 dir = ENC_NONE;
        endcase
        return dir;
    endfunction

endpackage

// File: src/dss_if.sv
// ============================================================================
// Drum step sequencer channels
// Valid/ready channels for panel polls and status results.
// ============================================================================
interface dss_in_if import dss_pkg::*;;
    logic    valid;
    logic    ready;
    dss_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dss_out_if import dss_pkg::*;;
    logic     valid;
    logic     ready;
    dss_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/dss_divider.sv
// ============================================================================
// Drum step sequencer serial divider
// Restoring divider, one quotient bit per cycle, for the step period.
// ============================================================================
module dss_divider import dss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BEAT_W-1:0]  dividend,
    input  logic [TEMPO_W-1:0] divisor,
    output logic               done,
    output logic [BEAT_W-1:0]  quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 done_reg;
    logic                 done_next;
    logic [TEMPO_W-1:0]   rem_reg;
    logic [TEMPO_W-1:0]   rem_next;
    logic [BEAT_W-1:0]    quo_reg;
    logic [BEAT_W-1:0]    quo_next;
    logic [TEMPO_W-1:0]   div_reg;
    logic [TEMPO_W-1:0]   div_next;
    logic [TEMPO_W:0]     rem_shift;
    logic                 rem_ge;
    logic [TEMPO_W:0]     rem_diff;

    // One trial subtraction per cycle.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[BEAT_W-1]};
        rem_ge    = (rem_shift >= {1'b0, div_reg});
        rem_diff  = rem_shift - {1'b0, div_reg};
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = DIV_CNT_W'(DIV_STEPS);
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            rem_next  = rem_ge ? rem_diff[TEMPO_W-1:0] : rem_shift[TEMPO_W-1:0];
            quo_next  = {quo_reg[BEAT_W-2:0], rem_ge};
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/drum_step_sequencer.sv
// ============================================================================
// Drum step sequencer
// 16-step drum pattern player with MIDI and panel editing.
// ============================================================================
// Usage:
//   poll carries one sample of the panel per request: the millisecond tick,
//   run switches, edit button, both encoders and an optional MIDI byte.
//   report returns one status request per poll: drum triggers, play and
//   cursor positions, edited row, tempo and the display value.
//   cfg_write_en / cfg_write_data load beat_constant; write it only while
//   no poll is in flight.
// Timing:
//   A poll is taken in the idle state; the step period beat_constant/tempo
//   is then computed by a serial divider at one quotient bit per cycle.
//   The status is loaded into the output register from the step state once
//   the divider is done; the next poll is taken only back in idle.
// Reset:
//   Pattern row 0 is all ones, row 4 holds every fourth step, tempo is 120,
//   beat_constant is 15000 and all positions are zero.
// Stalls:
//   A waiting status request holds the output register; the sequencer then
//   stays in the step state and accepts no poll until the register frees.
// ============================================================================
`include "drum_step_sequencer_defines.svh"

module drum_step_sequencer import dss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [BEAT_W-1:0] cfg_write_data,
    dss_in_if.sink            poll,
    dss_out_if.source         report
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_STEP = 3'b100
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [BEAT_W-1:0]    beat_reg;
    logic [NUM_STEPS-1:0] pattern_reg [NUM_ROWS];
    logic [NUM_STEPS-1:0] pattern_next [NUM_ROWS];
    logic [MIDI_W-1:0]    win_new_reg;
    logic [MIDI_W-1:0]    win_old_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [STEP_W-1:0]    cursor_reg;
    logic [STEP_W-1:0]    cursor_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [TEMPO_W-1:0]   tempo_reg;
    logic [TEMPO_W-1:0]   tempo_next;
    logic [TICK_W-1:0]    tick_count_reg;
    logic [TICK_W-1:0]    tick_count_next;
    logic                 button_seen_reg;
    logic [1:0]           left_last_reg;
    logic [1:0]           right_last_reg;
    logic [DRUM_CNT-1:0]  drum_reg;
    logic [DRUM_CNT-1:0]  drum_next;
    dss_in_t              poll_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    dss_out_t             out_reg;
    dss_out_t             out_next;

    logic                 poll_accept;
    logic                 out_push;
    logic                 div_done;
    logic [BEAT_W-1:0]    period;

    logic [MIDI_W-1:0]    note_col;
    logic                 midi_hit;
    logic                 button_rise;
    logic                 run;
    logic                 step_adv;
    logic [1:0]           left_code;
    logic [1:0]           right_code;
    enc_dir_t             left_dir;
    enc_dir_t             right_dir;
    logic [DISP_W-1:0]    disp_full;
    logic [STEP_W+POS_W-1:0]    step_ext;
    logic [STEP_W+POS_W-1:0]    cursor_ext;
    logic [ROW_W+ROW_OUT_W-1:0] row_ext;

    assign poll_accept  = poll.valid && poll.ready;
    assign poll.ready   = (state_reg == ST_IDLE);
    assign out_push     = (state_reg == ST_STEP) && (!out_valid_reg || report.ready);
    assign report.valid = out_valid_reg;
    assign report.data  = out_reg;

    // Step period from the serial divider.
    dss_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (poll_accept),
        .dividend (beat_reg),
        .divisor  (tempo_reg),
        .done     (div_done),
        .quotient (period)
    );

    // Sequencer control.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (poll_accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (out_push)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // MIDI note and edit button toggles, applied when the poll is taken.
    always_comb
    begin
        note_col    = win_new_reg - NOTE_BASE;
        midi_hit    = poll.data.midi_valid && (win_old_reg == NOTE_ON) &&
                      (win_new_reg >= NOTE_BASE) && (note_col < MIDI_W'(NUM_STEPS));
        button_rise = poll.data.edit_button && !button_seen_reg;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            pattern_next[r] = pattern_reg[r];
            if (r == 0 && midi_hit)
            begin
                pattern_next[r] = pattern_next[r] ^
                                  (NUM_STEPS'(1) << note_col[STEP_W-1:0]);
            end
            if (button_rise && (row_reg == ROW_W'(r)))
            begin
                pattern_next[r] = pattern_next[r] ^ (NUM_STEPS'(1) << cursor_reg);
            end
        end
    end

    // Step advance, gate end and encoder moves, once the period is known.
    always_comb
    begin
        run        = !(poll_reg.fwd_switch_n && poll_reg.back_switch_n);
        step_adv   = run && (tick_count_reg >= period);
        left_code  = {poll_reg.left_enc_b, poll_reg.left_enc_a};
        right_code = {poll_reg.right_enc_a, poll_reg.right_enc_b};
        left_dir   = enc_decode(left_last_reg, left_code);
        right_dir  = enc_decode(right_last_reg, right_code);

        tick_count_next = tick_count_reg;
        drum_next       = drum_reg;
        step_next       = step_reg;
        if (step_adv)
        begin
            tick_count_next = '0;
            for (int r = 0; r < DRUM_CNT; r++)
            begin
                drum_next[r] = pattern_reg[r][step_reg];
            end
            if (!poll_reg.fwd_switch_n)
            begin
                step_next = (step_reg == STEP_W'(NUM_STEPS - 1)) ? '0 : step_reg + 1'b1;
            end
            else
            begin
                step_next = (step_reg == '0) ? STEP_W'(NUM_STEPS - 1) : step_reg - 1'b1;
            end
        end
        if (tick_count_next >= {2'b00, period[BEAT_W-1:2]})
        begin
            drum_next = '0;
        end

        // Left encoder moves the cursor with wrap.
        cursor_next = cursor_reg;
        unique case (left_dir)
            ENC_UP:
            begin
                cursor_next = (cursor_reg == STEP_W'(NUM_STEPS - 1)) ? '0 : cursor_reg + 1'b1;
            end
            ENC_DOWN:
            begin
                cursor_next = (cursor_reg == '0) ? STEP_W'(NUM_STEPS - 1) : cursor_reg - 1'b1;
            end
            default:
            begin
                cursor_next = cursor_reg;
            end
        endcase

        // Right encoder sets the row while running, else the tempo.
        row_next   = row_reg;
        tempo_next = tempo_reg;
        if (run)
        begin
            if (right_dir == ENC_UP && row_reg != ROW_W'(NUM_ROWS - 1))
            begin
                row_next = row_reg + 1'b1;
            end
            else if (right_dir == ENC_DOWN && row_reg != '0)
            begin
                row_next = row_reg - 1'b1;
            end
        end
        else
        begin
            if (right_dir == ENC_UP && tempo_reg < TEMPO_MAX)
            begin
                tempo_next = tempo_reg + 1'b1;
            end
            else if (right_dir == ENC_DOWN && tempo_reg > TEMPO_MIN)
            begin
                tempo_next = tempo_reg - 1'b1;
            end
        end

        // Status word.
        disp_full  = run ? (DISP_W'(step_next) * DISP_W'(DISP_SCALE) + DISP_W'(cursor_next))
                         : DISP_W'(tempo_next);
        step_ext   = {{POS_W{1'b0}}, step_next};
        cursor_ext = {{POS_W{1'b0}}, cursor_next};
        row_ext    = {{ROW_OUT_W{1'b0}}, row_next};
        out_next.drum_triggers   = drum_next;
        out_next.play_position   = step_ext[POS_W-1:0];
        out_next.cursor_position = cursor_ext[POS_W-1:0];
        out_next.edit_row        = row_ext[ROW_OUT_W-1:0];
        out_next.tempo_now       = tempo_next;
        out_next.display_value   = disp_full[DISP_OUT_W-1:0];
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            beat_reg        <= BEAT_RESET;
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                pattern_reg[r] <= row_reset(r);
            end
            win_new_reg     <= '0;
            win_old_reg     <= '0;
            step_reg        <= '0;
            cursor_reg      <= '0;
            row_reg         <= '0;
            tempo_reg       <= TEMPO_RESET;
            tick_count_reg  <= '0;
            button_seen_reg <= 1'b0;
            left_last_reg   <= '0;
            right_last_reg  <= '0;
            drum_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                beat_reg <= cfg_write_data;
            end
            if (poll_accept)
            begin
                for (int r = 0; r < NUM_ROWS; r++)
                begin
                    pattern_reg[r] <= pattern_next[r];
                end
                if (poll.data.midi_valid)
                begin
                    win_old_reg <= win_new_reg;
                    win_new_reg <= poll.data.midi_byte;
                end
                if (poll.data.tick)
                begin
                    tick_count_reg <= tick_count_reg + 1'b1;
                end
                if (poll.data.fwd_switch_n && poll.data.back_switch_n)
                begin
                    step_reg <= '0;
                end
                button_seen_reg <= poll.data.edit_button;
            end
            if (out_push)
            begin
                tick_count_reg <= tick_count_next;
                drum_reg       <= drum_next;
                step_reg       <= step_next;
                cursor_reg     <= cursor_next;
                row_reg        <= row_next;
                tempo_reg      <= tempo_next;
                left_last_reg  <= left_code;
                right_last_reg <= right_code;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (poll_accept)
        begin
            poll_reg <= poll.data;
        end
        if (out_push)
        begin
            out_reg <= out_next;
        end
    end

    `DSS_ASSERT_ALWAYS(a_tempo_range, clk, rst_n, tempo_reg >= TEMPO_MIN && tempo_reg <= TEMPO_MAX, "tempo left its range")
    `DSS_ASSERT_ALWAYS(a_row_range, clk, rst_n, row_reg <= ROW_W'(NUM_ROWS - 1), "edit row left its range")
    `DSS_ASSERT_IMPL(a_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV, "divider finished outside the divide state")
    `DSS_ASSERT_NEXT(a_accept_starts_div, clk, rst_n, poll_accept, state_reg == ST_DIV, "accepted poll did not start the divider")
    `DSS_ASSERT_NEXT(a_push_loads_out, clk, rst_n, out_push, out_valid_reg && state_reg == ST_IDLE, "status push did not load the output")

endmodule
